// ===== rtl/kte_pkg.sv =====
`default_nettype none

package kte_pkg;

    // Position format: whole steps plus fraction bits
    localparam int FRAC_BITS = 8;
    localparam int POS_W     = 16 + FRAC_BITS;
    localparam int DIV_PAD   = 16 - FRAC_BITS;
    localparam int CHAN_N    = 9;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_TICK   = 3'd1,
        OP_PLAY   = 3'd2,
        OP_STOP   = 3'd3,
        OP_SETPOS = 3'd4,
        OP_RESET  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        KIND_POSE = 2'd0,
        KIND_PLAY = 2'd1,
        KIND_STOP = 2'd2,
        KIND_LOOP = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CFG_LOOP  = 3'd0,
        CFG_EASE  = 3'd1,
        CFG_COUNT = 3'd2,
        CFG_MASK  = 3'd3,
        CFG_TAG   = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_RD_A,
        S_RD_B,
        S_LD_B,
        S_DIV,
        S_EASE,
        S_CHAN,
        S_EMIT_POSE,
        S_EMIT_EVT
    } state_t;

    typedef struct packed {
        logic [15:0]        ktime;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic [7:0]         alpha;
        logic [31:0]        colour;
    } key_entry_t;

    // Quarter-wave sine, Q.16, 17 points
    function automatic logic [16:0] sine_q16(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:    r = 17'd0;
            5'd1:    r = 17'd6424;
            5'd2:    r = 17'd12785;
            5'd3:    r = 17'd19024;
            5'd4:    r = 17'd25080;
            5'd5:    r = 17'd30893;
            5'd6:    r = 17'd36410;
            5'd7:    r = 17'd41576;
            5'd8:    r = 17'd46341;
            5'd9:    r = 17'd50660;
            5'd10:   r = 17'd54491;
            5'd11:   r = 17'd57798;
            5'd12:   r = 17'd60547;
            5'd13:   r = 17'd62714;
            5'd14:   r = 17'd64277;
            5'd15:   r = 17'd65220;
            5'd16:   r = 17'd65536;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/keyframe_tween_engine.sv =====
// Play, stop, load, set position and reset are taken in idle; a play while stopped or a
// stop while playing emits one event item. A tick while playing scans the keyframe memory,
// reads the current and next keyframes, divides and eases if there is a next one, runs
// each channel on one shared multiplier, emits; a looping wrap with a key at 0 repeats it.
// One item is in work at a time; the output register holds a result while the next is built.
// Reset (rst_n low, asynchronous) clears play state, position and registers; keyframes keep.
`default_nettype none

module keyframe_tween_engine
    import kte_pkg::*;
#(
    parameter int KEYS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         op,
    input  wire logic [3:0]         key_index,
    input  wire logic [15:0]        key_time,
    input  wire logic signed [15:0] key_x,
    input  wire logic signed [15:0] key_y,
    input  wire logic signed [15:0] key_w,
    input  wire logic signed [15:0] key_h,
    input  wire logic [7:0]         key_alpha,
    input  wire logic [31:0]        key_colour,
    input  wire logic [15:0]        delta_steps,
    input  wire logic [23:0]        new_position,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              kind,
    output logic [15:0]             event_id,
    output logic signed [15:0]      pos_x,
    output logic signed [15:0]      pos_y,
    output logic signed [15:0]      width,
    output logic signed [15:0]      height,
    output logic [7:0]              opacity,
    output logic [31:0]             colour,
    output logic                    last,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    localparam int AW = $clog2(KEYS);
    localparam int CW = $clog2(KEYS + 1);

    // Configuration
    logic        loop_enable_reg;
    logic        ease_enable_reg;
    logic [4:0]  keyframe_count_reg;
    logic [5:0]  channel_mask_reg;
    logic [15:0] event_tag_reg;

    // Control
    state_t           state_reg, state_next;
    logic             playing_reg;
    logic [POS_W-1:0] pos_reg;

    // Keyframe memory
    key_entry_t mem [KEYS];
    key_entry_t rdata_reg;
    logic [AW-1:0] raddr;

    // Scan
    logic [CW-1:0] cnt_reg;
    logic          ev_v_reg;
    logic [AW-1:0] ev_idx_reg;
    logic [AW-1:0] cur_reg, nxt_reg;
    logic          cur_found_reg, nxt_found_reg;
    logic [15:0]   tc_reg, tn_reg, tlast_reg;
    logic          has_zero_reg;
    logic          second_reg;

    // Result sequencing
    logic  pose_last_reg;
    kind_t evt_kind_reg;
    logic  evt_last_reg;
    logic  evt_tick_reg;

    // Pose datapath
    key_entry_t  a_reg, b_reg;
    logic [15:0] rem_reg, numlo_reg, q_reg, den_reg;
    logic [3:0]  dcnt_reg;
    logic [15:0] f_reg;
    logic [3:0]  chan_reg;
    logic signed [15:0] res_x_reg, res_y_reg, res_w_reg, res_h_reg;
    logic [7:0]  res_alpha_reg;
    logic [31:0] res_colour_reg;

    // Output register
    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [15:0] out_id_reg;
    logic signed [15:0] out_x_reg, out_y_reg, out_w_reg, out_h_reg;
    logic [7:0]  out_alpha_reg;
    logic [31:0] out_colour_reg;
    logic        out_last_reg;

    logic             accept;
    logic [CW-1:0]    n_keys;
    logic             scan_done;
    logic             overflow;
    logic             out_free;
    logic             emit_go;
    logic [POS_W:0]   pos_sum;
    logic [POS_W-1:0] pos_tick;
    logic [POS_W-1:0] scan_t;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Clamp the key count to the table depth
    always_comb
    begin
        if (int'(keyframe_count_reg) > KEYS)
        begin
            n_keys = CW'(KEYS);
        end
        else
        begin
            n_keys = CW'(keyframe_count_reg);
        end
    end

    assign pos_sum  = {1'b0, pos_reg} + {{(POS_W + 1 - 16){1'b0}}, delta_steps};
    assign pos_tick = pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
    assign scan_t   = {rdata_reg.ktime, {FRAC_BITS{1'b0}}};

    assign scan_done = (cnt_reg == n_keys) && !ev_v_reg;
    assign overflow  = (n_keys == '0) ? (pos_reg != '0)
                                      : (pos_reg > {tlast_reg, {FRAC_BITS{1'b0}}});

    // Pick the memory read address
    always_comb
    begin
        case (state_reg)
            S_SCAN:  raddr = cnt_reg[AW-1:0];
            S_RD_A:  raddr = cur_reg;
            S_RD_B:  raddr = nxt_reg;
            default: raddr = cur_reg;
        endcase
    end

    // Write keyframes; the read data is registered
    always_ff @(posedge clk)
    begin
        if (accept && (op_t'(op) == OP_LOAD) && (int'(key_index) < KEYS))
        begin
            mem[AW'(key_index)] <= '{ktime: key_time, x: key_x, y: key_y, w: key_w,
                                     h: key_h, alpha: key_alpha, colour: key_colour};
        end
        rdata_reg <= mem[raddr];
    end

    // Divider step
    logic [16:0] div_t;
    logic        div_ge;
    logic [16:0] div_sub;
    assign div_t   = {rem_reg, numlo_reg[15]};
    assign div_ge  = div_t >= {1'b0, den_reg};
    assign div_sub = div_t - {1'b0, den_reg};

    // Division operands from the scan result
    logic [POS_W-1:0]         a_diff;
    logic [POS_W+DIV_PAD-1:0] div_num;
    assign a_diff  = pos_reg - {tc_reg, {FRAC_BITS{1'b0}}};
    assign div_num = {a_diff, {DIV_PAD{1'b0}}};

    // Sine ease from the quarter-wave table
    logic [16:0] sin_lo, sin_hi, sin_diff;
    logic [28:0] sin_prod;
    logic [16:0] ease_sum;
    assign sin_lo   = sine_q16({1'b0, q_reg[15:12]});
    assign sin_hi   = sine_q16({1'b0, q_reg[15:12]} + 5'd1);
    assign sin_diff = sin_hi - sin_lo;
    assign sin_prod = 29'(sin_diff) * 29'(q_reg[11:0]);
    assign ease_sum = sin_lo + 17'(sin_prod >> 12);

    // Channel interpolation on one shared multiplier
    logic signed [16:0] ch_a, ch_b;
    logic               ch_en;
    logic signed [17:0] ch_d;
    logic [16:0]        ch_mag;
    logic [32:0]        ch_prod;
    logic [16:0]        ch_p;
    logic signed [17:0] ch_v;
    logic [1:0]         ch_byte;

    assign ch_byte = 2'(chan_reg - 4'd5);

    always_comb
    begin
        case (chan_reg)
            4'd0:
            begin
                ch_a = 17'(a_reg.x);
                ch_b = 17'(b_reg.x);
                ch_en = channel_mask_reg[0];
            end
            4'd1:
            begin
                ch_a = 17'(a_reg.y);
                ch_b = 17'(b_reg.y);
                ch_en = channel_mask_reg[1];
            end
            4'd2:
            begin
                ch_a = 17'(a_reg.w);
                ch_b = 17'(b_reg.w);
                ch_en = channel_mask_reg[2];
            end
            4'd3:
            begin
                ch_a = 17'(a_reg.h);
                ch_b = 17'(b_reg.h);
                ch_en = channel_mask_reg[3];
            end
            4'd4:
            begin
                ch_a = {9'd0, a_reg.alpha};
                ch_b = {9'd0, b_reg.alpha};
                ch_en = channel_mask_reg[4];
            end
            default:
            begin
                ch_a = {9'd0, a_reg.colour[8*ch_byte +: 8]};
                ch_b = {9'd0, b_reg.colour[8*ch_byte +: 8]};
                ch_en = channel_mask_reg[5];
            end
        endcase
        ch_d    = 18'(ch_b) - 18'(ch_a);
        ch_mag  = ch_d[17] ? 17'(-ch_d) : 17'(ch_d);
        ch_prod = 33'(ch_mag) * 33'(f_reg);
        ch_p    = ch_prod[32:16];
        ch_v    = ch_d[17] ? (18'(ch_a) - 18'(ch_p)) : (18'(ch_a) + 18'(ch_p));
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and emit strobe
    always_comb
    begin
        state_next = state_reg;
        emit_go    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (op_t'(op))
                        OP_TICK:
                        begin
                            if (playing_reg)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_PLAY:
                        begin
                            if (!playing_reg)
                            begin
                                state_next = S_EMIT_EVT;
                            end
                        end
                        OP_STOP:
                        begin
                            if (playing_reg)
                            begin
                                state_next = S_EMIT_EVT;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    if (cur_found_reg)
                    begin
                        state_next = S_RD_A;
                    end
                    else if (!second_reg && overflow)
                    begin
                        state_next = S_EMIT_EVT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RD_A: state_next = S_RD_B;
            S_RD_B: state_next = nxt_found_reg ? S_LD_B : S_CHAN;
            S_LD_B: state_next = S_DIV;
            S_DIV:
            begin
                if (dcnt_reg == 4'd0)
                begin
                    state_next = S_EASE;
                end
            end
            S_EASE: state_next = S_CHAN;
            S_CHAN:
            begin
                if (chan_reg == 4'(CHAN_N - 1))
                begin
                    state_next = S_EMIT_POSE;
                end
            end
            S_EMIT_POSE:
            begin
                if (out_free)
                begin
                    emit_go    = 1'b1;
                    state_next = pose_last_reg ? S_IDLE : S_EMIT_EVT;
                end
            end
            S_EMIT_EVT:
            begin
                if (out_free)
                begin
                    emit_go    = 1'b1;
                    state_next = (evt_tick_reg && !evt_last_reg) ? S_SCAN : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Configuration, play state, scan and sequencing control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_enable_reg    <= 1'b0;
            ease_enable_reg    <= 1'b0;
            keyframe_count_reg <= '0;
            channel_mask_reg   <= '0;
            event_tag_reg      <= 16'hFFFF;
            playing_reg        <= 1'b0;
            pos_reg            <= '0;
            cnt_reg            <= '0;
            ev_v_reg           <= 1'b0;
            cur_found_reg      <= 1'b0;
            nxt_found_reg      <= 1'b0;
            has_zero_reg       <= 1'b0;
            second_reg         <= 1'b0;
            pose_last_reg      <= 1'b0;
            evt_kind_reg       <= KIND_PLAY;
            evt_last_reg       <= 1'b0;
            evt_tick_reg       <= 1'b0;
            dcnt_reg           <= '0;
            chan_reg           <= '0;
        end
        else
        begin
            // Take register writes
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_LOOP:  loop_enable_reg    <= cfg_data[0];
                    CFG_EASE:  ease_enable_reg    <= cfg_data[0];
                    CFG_COUNT: keyframe_count_reg <= cfg_data[4:0];
                    CFG_MASK:  channel_mask_reg   <= cfg_data[5:0];
                    CFG_TAG:   event_tag_reg      <= cfg_data;
                    default:   ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (op_t'(op))
                            OP_TICK:
                            begin
                                if (playing_reg)
                                begin
                                    pos_reg       <= pos_tick;
                                    second_reg    <= 1'b0;
                                    cnt_reg       <= '0;
                                    ev_v_reg      <= 1'b0;
                                    cur_found_reg <= 1'b0;
                                    nxt_found_reg <= 1'b0;
                                    has_zero_reg  <= 1'b0;
                                end
                            end
                            OP_PLAY:
                            begin
                                if (!playing_reg)
                                begin
                                    playing_reg  <= 1'b1;
                                    evt_kind_reg <= KIND_PLAY;
                                    evt_last_reg <= 1'b1;
                                    evt_tick_reg <= 1'b0;
                                end
                            end
                            OP_STOP:
                            begin
                                if (playing_reg)
                                begin
                                    playing_reg  <= 1'b0;
                                    evt_kind_reg <= KIND_STOP;
                                    evt_last_reg <= 1'b1;
                                    evt_tick_reg <= 1'b0;
                                end
                            end
                            OP_SETPOS: pos_reg <= POS_W'(new_position);
                            OP_RESET:
                            begin
                                playing_reg <= 1'b0;
                                pos_reg     <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    // Issue the next slot, evaluate the one read last cycle
                    if (cnt_reg < n_keys)
                    begin
                        cnt_reg  <= cnt_reg + 1'b1;
                        ev_v_reg <= 1'b1;
                    end
                    else
                    begin
                        ev_v_reg <= 1'b0;
                    end
                    if (ev_v_reg)
                    begin
                        if (scan_t <= pos_reg)
                        begin
                            cur_found_reg <= 1'b1;
                        end
                        else if (!nxt_found_reg)
                        begin
                            nxt_found_reg <= 1'b1;
                        end
                        if (rdata_reg.ktime == 16'd0)
                        begin
                            has_zero_reg <= 1'b1;
                        end
                    end
                    // Decide what the tick emits
                    if (scan_done)
                    begin
                        if (!second_reg && overflow)
                        begin
                            pose_last_reg <= 1'b0;
                            evt_kind_reg  <= loop_enable_reg ? KIND_LOOP : KIND_STOP;
                            evt_last_reg  <= !(loop_enable_reg && has_zero_reg);
                            evt_tick_reg  <= 1'b1;
                        end
                        else
                        begin
                            pose_last_reg <= 1'b1;
                        end
                    end
                end
                S_RD_B:
                begin
                    if (!nxt_found_reg)
                    begin
                        chan_reg <= '0;
                    end
                end
                S_LD_B: dcnt_reg <= 4'd15;
                S_DIV:  dcnt_reg <= dcnt_reg - 4'd1;
                S_EASE: chan_reg <= '0;
                S_CHAN: chan_reg <= chan_reg + 4'd1;
                S_EMIT_EVT:
                begin
                    // Wrap or stop at the end of the timeline
                    if (emit_go && evt_tick_reg)
                    begin
                        playing_reg <= loop_enable_reg;
                        pos_reg     <= '0;
                        if (!evt_last_reg)
                        begin
                            second_reg    <= 1'b1;
                            cnt_reg       <= '0;
                            ev_v_reg      <= 1'b0;
                            cur_found_reg <= 1'b0;
                            nxt_found_reg <= 1'b0;
                            has_zero_reg  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Scan payload and pose datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_SCAN:
            begin
                if (cnt_reg < n_keys)
                begin
                    ev_idx_reg <= cnt_reg[AW-1:0];
                end
                if (ev_v_reg)
                begin
                    tlast_reg <= rdata_reg.ktime;
                    if (scan_t <= pos_reg)
                    begin
                        cur_reg <= ev_idx_reg;
                        tc_reg  <= rdata_reg.ktime;
                    end
                    else if (!nxt_found_reg)
                    begin
                        nxt_reg <= ev_idx_reg;
                        tn_reg  <= rdata_reg.ktime;
                    end
                end
            end
            S_RD_B:
            begin
                a_reg <= rdata_reg;
                if (!nxt_found_reg)
                begin
                    b_reg <= rdata_reg;
                    f_reg <= '0;
                end
            end
            S_LD_B:
            begin
                b_reg     <= rdata_reg;
                rem_reg   <= div_num[POS_W+DIV_PAD-1 -: 16];
                numlo_reg <= div_num[15:0];
                den_reg   <= tn_reg - tc_reg;
                q_reg     <= '0;
            end
            S_DIV:
            begin
                rem_reg   <= div_ge ? div_sub[15:0] : div_t[15:0];
                q_reg     <= {q_reg[14:0], div_ge};
                numlo_reg <= {numlo_reg[14:0], 1'b0};
            end
            S_EASE: f_reg <= ease_enable_reg ? ease_sum[15:0] : q_reg;
            S_CHAN:
            begin
                case (chan_reg)
                    4'd0: res_x_reg <= ch_en ? ch_v[15:0] : 16'sd0;
                    4'd1: res_y_reg <= ch_en ? ch_v[15:0] : 16'sd0;
                    4'd2: res_w_reg <= ch_en ? ch_v[15:0] : 16'sd0;
                    4'd3: res_h_reg <= ch_en ? ch_v[15:0] : 16'sd0;
                    4'd4: res_alpha_reg <= ch_en ? ch_v[7:0] : 8'd0;
                    default: res_colour_reg[8*ch_byte +: 8] <= ch_en ? ch_v[7:0] : 8'd0;
                endcase
            end
            default: ;
        endcase
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the output register with a pose or an event
    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            if (state_reg == S_EMIT_POSE)
            begin
                out_kind_reg   <= KIND_POSE;
                out_id_reg     <= '0;
                out_x_reg      <= res_x_reg;
                out_y_reg      <= res_y_reg;
                out_w_reg      <= res_w_reg;
                out_h_reg      <= res_h_reg;
                out_alpha_reg  <= res_alpha_reg;
                out_colour_reg <= res_colour_reg;
                out_last_reg   <= pose_last_reg;
            end
            else
            begin
                out_kind_reg   <= evt_kind_reg;
                out_id_reg     <= event_tag_reg;
                out_x_reg      <= '0;
                out_y_reg      <= '0;
                out_w_reg      <= '0;
                out_h_reg      <= '0;
                out_alpha_reg  <= '0;
                out_colour_reg <= '0;
                out_last_reg   <= evt_last_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign event_id  = out_id_reg;
    assign pos_x     = out_x_reg;
    assign pos_y     = out_y_reg;
    assign width     = out_w_reg;
    assign height    = out_h_reg;
    assign opacity   = out_alpha_reg;
    assign colour    = out_colour_reg;
    assign last      = out_last_reg;

`ifndef NO_ASSERTIONS
    a_event_no_pose: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_kind_reg != KIND_POSE)) |-> ((out_x_reg == '0) && (out_colour_reg == '0)))
        else $error("event item carries pose data");

    a_pose_no_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_kind_reg == KIND_POSE)) |-> (out_id_reg == '0))
        else $error("pose item carries an event tag");

    a_read_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_A) |-> cur_found_reg)
        else $error("pose read without a current keyframe");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder out of range");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && !emit_go) |=> out_valid)
        else $error("result dropped while stalled");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_keyframe_tween_engine.sv =====
`timescale 1ns / 1ps

module tb_keyframe_tween_engine;
    import kte_pkg::*;

    typedef struct {
        logic [2:0]         op;
        logic [3:0]         key_index;
        logic [15:0]        key_time;
        logic signed [15:0] key_x;
        logic signed [15:0] key_y;
        logic signed [15:0] key_w;
        logic signed [15:0] key_h;
        logic [7:0]         key_alpha;
        logic [31:0]        key_colour;
        logic [15:0]        delta_steps;
        logic [23:0]        new_position;
    } stim_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        event_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] width;
        logic signed [15:0] height;
        logic [7:0]         opacity;
        logic [31:0]        colour;
        logic               last;
    } frame_t;

    typedef struct {
        int          x;
        int          y;
        int          w;
        int          h;
        int          alpha;
        logic [31:0] colour;
    } key_t;

    class tween_scoreboard;
        bit          loop_en;
        bit          ease_en;
        bit [4:0]    key_count;
        bit [5:0]    chan_mask;
        bit [15:0]   tag = 16'hFFFF;
        bit [15:0]   key_times[16];
        key_t        key_vals[16];
        bit          playing;
        bit [23:0]   position;
        int          sine_pts[17] = '{0, 6424, 12785, 19024, 25080, 30893, 36410, 41576,
                                      46341, 50660, 54491, 57798, 60547, 62714, 64277,
                                      65220, 65536};
        frame_t      pending_frames[$];
        int          errors;

        function void set_reg(cfg_idx_t idx, logic [15:0] d);
            case (idx)
                CFG_LOOP:  loop_en   = d[0];
                CFG_EASE:  ease_en   = d[0];
                CFG_COUNT: key_count = d[4:0];
                CFG_MASK:  chan_mask = d[5:0];
                CFG_TAG:   tag       = d;
                default: ;
            endcase
        endfunction

        // queue an expected result at the tail
        function void add_frame(frame_t r);
            pending_frames.insert(pending_frames.size(), r);
        endfunction

        // scale a difference by a Q0.16 weight, truncating toward zero
        function int scaled(int d, longint f);
            longint m;
            longint p;
            m = (d < 0) ? -d : d;
            p = (m * f) >>> 16;
            return (d < 0) ? -int'(p) : int'(p);
        endfunction

        function longint eased(longint s);
            int k;
            int fr;
            k  = int'(s >> 12);
            fr = int'(s & 'hFFF);
            return sine_pts[k] + (((sine_pts[k + 1] - sine_pts[k]) * fr) >>> 12);
        endfunction

        // pose at a position; returns 0 when no keyframe lies at or before it
        function bit pose_at(longint pos, output frame_t r);
            int     n;
            int     cur;
            int     nxt;
            longint tc;
            longint tn;
            longint q;
            longint f;
            key_t   a;
            key_t   b;
            int     ca;
            int     cb;
            n   = (key_count > 16) ? 16 : key_count;
            cur = -1;
            nxt = -1;
            f   = 0;
            r   = '{default: 0};
            for (int i = n - 1; i >= 0; i--)
            begin
                if ((longint'(key_times[i]) << 8) <= pos)
                begin
                    cur = i;
                    break;
                end
            end
            if (cur < 0)
                return 0;
            for (int i = 0; i < n; i++)
            begin
                if ((longint'(key_times[i]) << 8) > pos)
                begin
                    nxt = i;
                    break;
                end
            end
            a = key_vals[cur];
            b = a;
            if (nxt >= 0)
            begin
                tc = longint'(key_times[cur]) << 8;
                tn = longint'(key_times[nxt]) << 8;
                q  = 0;
                if (tn > tc && pos >= tc)
                begin
                    q = ((pos - tc) << 16) / (tn - tc);
                    if (q > 65535)
                        q = 65535;
                end
                f = ease_en ? eased(q) : q;
                b = key_vals[nxt];
            end
            r.kind = KIND_POSE;
            if (chan_mask[0]) r.pos_x  = 16'(a.x + scaled(b.x - a.x, f));
            if (chan_mask[1]) r.pos_y  = 16'(a.y + scaled(b.y - a.y, f));
            if (chan_mask[2]) r.width  = 16'(a.w + scaled(b.w - a.w, f));
            if (chan_mask[3]) r.height = 16'(a.h + scaled(b.h - a.h, f));
            if (chan_mask[4]) r.opacity = 8'(a.alpha + scaled(b.alpha - a.alpha, f));
            if (chan_mask[5])
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ca = int'(a.colour[8*i +: 8]);
                    cb = int'(b.colour[8*i +: 8]);
                    r.colour[8*i +: 8] = 8'(ca + scaled(cb - ca, f));
                end
            end
            return 1;
        endfunction

        function void push_event(kind_t k);
            frame_t r;
            r = '{default: 0};
            r.kind     = k;
            r.event_id = tag;
            add_frame(r);
        endfunction

        // work out the results of one accepted item
        function void note_input(stim_t it);
            int     start;
            int     kc;
            longint total;
            longint p;
            frame_t r;
            start = pending_frames.size();
            case (it.op)
                OP_LOAD:
                begin
                    key_times[it.key_index]      = it.key_time;
                    key_vals[it.key_index].x      = int'(it.key_x);
                    key_vals[it.key_index].y      = int'(it.key_y);
                    key_vals[it.key_index].w      = int'(it.key_w);
                    key_vals[it.key_index].h      = int'(it.key_h);
                    key_vals[it.key_index].alpha  = int'(it.key_alpha);
                    key_vals[it.key_index].colour = it.key_colour;
                end
                OP_TICK:
                begin
                    if (playing)
                    begin
                        kc    = (key_count > 16) ? 16 : key_count;
                        total = kc ? (longint'(key_times[kc - 1]) << 8) : 0;
                        p     = longint'(position) + it.delta_steps;
                        if (p > 'hFFFFFF)
                            p = 'hFFFFFF;
                        position = p[23:0];
                        if (p > total)
                        begin
                            if (pose_at(p, r))
                                add_frame(r);
                            playing  = loop_en;
                            position = 0;
                            push_event(playing ? KIND_LOOP : KIND_STOP);
                        end
                        if (playing && pose_at(position, r))
                            add_frame(r);
                    end
                end
                OP_PLAY:
                begin
                    if (!playing)
                    begin
                        playing = 1;
                        push_event(KIND_PLAY);
                    end
                end
                OP_STOP:
                begin
                    if (playing)
                    begin
                        playing = 0;
                        push_event(KIND_STOP);
                    end
                end
                OP_SETPOS: position = it.new_position;
                OP_RESET:
                begin
                    playing  = 0;
                    position = 0;
                end
                default: ;
            endcase
            if (pending_frames.size() > start)
                pending_frames[pending_frames.size() - 1].last = 1;
        endfunction

        function void check_result(frame_t got);
            frame_t want;
            if (pending_frames.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result kind=%0d id=%h", got.kind, got.event_id);
                return;
            end
            want = pending_frames.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("result differs: exp %0d %h %h %h %h %h %h %h %b, got %0d %h %h %h %h %h %h %h %b",
                             want.kind, want.event_id, want.pos_x, want.pos_y, want.width,
                             want.height, want.opacity, want.colour, want.last,
                             got.kind, got.event_id, got.pos_x, got.pos_y, got.width,
                             got.height, got.opacity, got.colour, got.last);
            end
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [2:0]         op = '0;
    logic [3:0]         key_index = '0;
    logic [15:0]        key_time = '0;
    logic signed [15:0] key_x = '0;
    logic signed [15:0] key_y = '0;
    logic signed [15:0] key_w = '0;
    logic signed [15:0] key_h = '0;
    logic [7:0]         key_alpha = '0;
    logic [31:0]        key_colour = '0;
    logic [15:0]        delta_steps = '0;
    logic [23:0]        new_position = '0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [1:0]         kind;
    logic [15:0]        event_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] width;
    logic signed [15:0] height;
    logic [7:0]         opacity;
    logic [31:0]        colour;
    logic               last;
    logic               cfg_we = 0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    tween_scoreboard    sb = new;
    bit                 calm;
    int                 stall_left;
    int                 spacing = 12;

    keyframe_tween_engine u_top (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("keyframe_tween_engine: mismatch");
        $finish;
    end

    // mostly short gaps, a few long ones, none in calm stretches
    function int gap_len();
        int r;
        r = $urandom_range(99);
        if (calm || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stall the result side at random
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1;
        end
        else
        begin
            stall_left <= gap_len();
            out_stall  <= 0;
        end
    end

    // check every accepted result
    always @(posedge clk)
    begin
        frame_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind, event_id, pos_x, pos_y, width, height, opacity, colour, last};
            sb.check_result(got);
        end
    end

    task automatic send(stim_t it);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        op           <= it.op;
        key_index    <= it.key_index;
        key_time     <= it.key_time;
        key_x        <= it.key_x;
        key_y        <= it.key_y;
        key_w        <= it.key_w;
        key_h        <= it.key_h;
        key_alpha    <= it.key_alpha;
        key_colour   <= it.key_colour;
        delta_steps  <= it.delta_steps;
        new_position <= it.new_position;
        in_valid     <= 1;
        do @(posedge clk); while (in_stall);
        sb.note_input(it);
    endtask

    // write enable stays high for back-to-back writes; the caller drops it
    task automatic write_reg(cfg_idx_t idx, logic [15:0] d);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        sb.set_reg(idx, d);
    endtask

    // drop valid, drain results, then cover any result-free work still running
    task automatic settle();
        in_valid <= 0;
        while (sb.pending_frames.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function stim_t noise_item(logic [2:0] o);
        stim_t it;
        it = '{o, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 8'($urandom), $urandom, 16'($urandom), 24'($urandom)};
        return it;
    endfunction

    function stim_t rand_item();
        stim_t it;
        int    r;
        r = $urandom_range(99);
        it = noise_item(OP_TICK);
        if (r < 45)
        begin
            if ($urandom_range(9) != 0)
                it.delta_steps = 16'($urandom_range(0, spacing * 256));
        end
        else if (r < 57)
            it.op = OP_PLAY;
        else if (r < 63)
            it.op = OP_STOP;
        else if (r < 76)
        begin
            it.op = OP_LOAD;
            if ($urandom_range(6) != 0)
                it.key_time = 16'(int'(it.key_index) * spacing +
                                  int'($urandom_range(0, spacing - 1)));
        end
        else if (r < 84)
        begin
            it.op = OP_SETPOS;
            if ($urandom_range(3) != 0)
                it.new_position = 24'($urandom_range(0, 16 * spacing * 256));
        end
        else if (r < 89)
            it.op = OP_RESET;
        else if (r < 93)
            it.op = 3'($urandom_range(6, 7));
        return it;
    endfunction

    task automatic run_phase(bit lp, bit ez, logic [4:0] cnt, logic [5:0] msk, logic [15:0] tg);
        settle();
        write_reg(CFG_LOOP, 16'(lp));
        write_reg(CFG_EASE, 16'(ez));
        write_reg(CFG_COUNT, 16'(cnt));
        write_reg(CFG_MASK, 16'(msk));
        write_reg(CFG_TAG, tg);
        cfg_we <= 0;
        spacing = $urandom_range(3, 40);
        for (int i = 0; i < 45; i++)
        begin
            calm = (i >= 20 && i < 28);
            send(rand_item());
        end
        calm = 0;
    endtask

    initial
    begin
        stim_t it;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // stopped tick, empty table end-of-timeline stop, play/stop edges, ignored codes, set position, reset
        it = noise_item(OP_TICK);   send(it);
        it = noise_item(OP_PLAY);   send(it);
        it = noise_item(OP_TICK);   it.delta_steps = 16'd1; send(it);
        it = noise_item(OP_PLAY);   send(it);
        it = noise_item(OP_STOP);   send(it);
        it = noise_item(OP_STOP);   send(it);
        it = noise_item(3'd6);      send(it);
        it = noise_item(3'd7);      send(it);
        it = noise_item(OP_SETPOS); it.new_position = 24'hFFFFFF; send(it);
        it = noise_item(OP_RESET);  send(it);

        // fill every slot, ascending times, extreme values
        for (int i = 0; i < 16; i++)
        begin
            it = noise_item(OP_LOAD);
            it.key_index  = 4'(i);
            it.key_time   = 16'(i * 12);
            it.key_x      = i[0] ? 16'sh7FFF : 16'sh8000;
            it.key_y      = i[0] ? 16'sh8000 : 16'sh7FFF;
            it.key_alpha  = i[0] ? 8'hFF : 8'h00;
            it.key_colour = i[0] ? 32'hFFFFFFFF : 32'h0;
            send(it);
        end

        // register settings, extremes among them
        run_phase(1, 0, 5'd16, 6'h3F, 16'h0000);
        run_phase(0, 1, 5'd16, 6'h3F, 16'hFFFF);
        run_phase(1, 1, 5'd1, 6'h3F, 16'h1234);
        run_phase(0, 0, 5'd31, 6'h15, 16'hA5A5);
        run_phase(1, 1, 5'd0, 6'h2A, 16'h5A5A);
        run_phase(1, 0, 5'd2, 6'h3F, 16'($urandom));
        run_phase(0, 1, 5'd8, 6'h00, 16'($urandom));
        run_phase(1, 1, 5'($urandom_range(0, 31)), 6'($urandom), 16'($urandom));

        settle();
        if (sb.errors == 0 && sb.pending_frames.size() == 0)
            $display("keyframe_tween_engine: match");
        else
            $display("keyframe_tween_engine: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kte_pkg.sv
rtl/keyframe_tween_engine.sv
verif/tb_keyframe_tween_engine.sv
